>>> sv/mtee_pkg.sv
// Shared types and constants of the MIDI track event encoder.
package mtee_pkg;

    // Item kinds carried on the input tuser field.
    typedef enum logic [3:0] {
        MODE_DELAY    = 4'd0,
        MODE_KEY_ON   = 4'd1,
        MODE_KEY_OFF  = 4'd2,
        MODE_KEY_TOUCH = 4'd3,
        MODE_CONTROL  = 4'd4,
        MODE_PATCH    = 4'd5,
        MODE_WHEEL    = 4'd6,
        MODE_META     = 4'd7,
        MODE_PAYLOAD  = 4'd8
    } mode_t;

    localparam int S_TDATA_W = 56;
    localparam int DELAY_W   = 28;
    localparam int MAX_BYTES = 7;
    localparam int COUNT_W   = 3;

    localparam logic [DELAY_W-1:0] DELAY_MAX = 28'hFFFFFFF;

    localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
    localparam logic [7:0] KIND_NOTE_OFF = 8'h80;
    localparam logic [7:0] KIND_TOUCH    = 8'hA0;
    localparam logic [7:0] KIND_CONTROL  = 8'hB0;
    localparam logic [7:0] KIND_PATCH    = 8'hC0;
    localparam logic [7:0] KIND_WHEEL    = 8'hE0;
    localparam logic [7:0] META_MARK     = 8'hFF;
    localparam logic [7:0] SEVEN_MASK    = 8'h7F;
    localparam logic [7:0] VLQ_MORE      = 8'h80;

    typedef logic [MAX_BYTES-1:0][7:0] byte_arr_t;

    // One input item as held in the input register.
    typedef struct packed {
        logic [3:0]        mode;
        logic [3:0]        channel;
        logic signed [8:0] first_data;
        logic [7:0]        second_data;
        logic [13:0]       wheel_value;
        logic [15:0]       delay_ticks;
    } item_t;

    // Encoder answer for one item: bytes in send order and the new state.
    typedef struct packed {
        byte_arr_t            bytes;
        logic [COUNT_W-1:0]   count;
        logic [DELAY_W-1:0]   pending_next;
        logic [7:0]           status_next;
    } enc_result_t;

endpackage

>>> sv/mtee_encode.sv
// Combinational encoder: one item plus state into up to seven track bytes.
module mtee_encode
    import mtee_pkg::*;
(
    input  item_t              item,
    input  logic [DELAY_W-1:0] pending,
    input  logic [7:0]         last_status,
    output enc_result_t        result
);

    always_comb
    begin
        logic [DELAY_W:0]   sum;
        logic [7:0]         status;
        logic               flush;
        logic               send_status;
        byte_arr_t          b;
        logic [COUNT_W-1:0] n;

        sum         = {1'b0, pending} + {{(DELAY_W - 15){1'b0}}, item.delay_ticks};
        status      = 8'h00;
        flush       = 1'b0;
        send_status = 1'b0;
        b           = '0;
        n           = '0;
        result.pending_next = pending;
        result.status_next  = last_status;

        case (item.mode)
            MODE_KEY_ON:
            begin
                flush  = !item.first_data[8];
                status = KIND_NOTE_ON | {4'h0, item.channel};
            end
            MODE_KEY_OFF:
            begin
                flush  = !item.first_data[8];
                status = KIND_NOTE_OFF | {4'h0, item.channel};
            end
            MODE_KEY_TOUCH:
            begin
                flush  = !item.first_data[8];
                status = KIND_TOUCH | {4'h0, item.channel};
            end
            MODE_CONTROL:
            begin
                flush  = 1'b1;
                status = KIND_CONTROL | {4'h0, item.channel};
            end
            MODE_PATCH:
            begin
                flush  = 1'b1;
                status = KIND_PATCH | {4'h0, item.channel};
            end
            MODE_WHEEL:
            begin
                flush  = 1'b1;
                status = KIND_WHEEL | {4'h0, item.channel};
            end
            MODE_META:
            begin
                flush = 1'b1;
            end
            default:
            begin
                flush = 1'b0;
            end
        endcase

        if (item.mode == MODE_DELAY) begin
            if (sum >= {1'b0, DELAY_MAX})
                result.pending_next = DELAY_MAX;
            else
                result.pending_next = sum[DELAY_W-1:0];
        end

        // Pending delay as a variable-length quantity, high group first.
        if (flush) begin
            if (pending[27:21] != 7'd0) begin
                b[n] = VLQ_MORE | {1'b0, pending[27:21]};
                n    = n + 1'b1;
            end
            if (pending[27:14] != 14'd0) begin
                b[n] = VLQ_MORE | {1'b0, pending[20:14]};
                n    = n + 1'b1;
            end
            if (pending[27:7] != 21'd0) begin
                b[n] = VLQ_MORE | {1'b0, pending[13:7]};
                n    = n + 1'b1;
            end
            b[n] = {1'b0, pending[6:0]};
            n    = n + 1'b1;
            result.pending_next = '0;
        end

        // Channel events share running status; meta events leave it alone.
        send_status = flush && (item.mode != MODE_META) && (status != last_status);
        if (send_status) begin
            b[n] = status;
            n    = n + 1'b1;
            result.status_next = status;
        end

        if (flush) begin
            case (item.mode)
                MODE_WHEEL:
                begin
                    b[n] = {1'b0, item.wheel_value[6:0]};
                    n    = n + 1'b1;
                    b[n] = {1'b0, item.wheel_value[13:7]};
                    n    = n + 1'b1;
                end
                MODE_PATCH:
                begin
                    b[n] = item.first_data[7:0];
                    n    = n + 1'b1;
                end
                MODE_META:
                begin
                    b[n] = META_MARK;
                    n    = n + 1'b1;
                    b[n] = item.first_data[7:0];
                    n    = n + 1'b1;
                    b[n] = item.second_data;
                    n    = n + 1'b1;
                end
                default:
                begin
                    b[n] = item.first_data[7:0];
                    n    = n + 1'b1;
                    b[n] = item.second_data;
                    n    = n + 1'b1;
                end
            endcase
        end else if (item.mode == MODE_PAYLOAD) begin
            b[n] = item.first_data[7:0];
            n    = n + 1'b1;
        end

        result.bytes = b;
        result.count = n;
    end

endmodule

>>> sv/mtee_burst.sv
// Result register that sends the bytes of one item out one per cycle while m_tready is high.
module mtee_burst
    import mtee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  byte_arr_t          load_bytes,
    input  logic [COUNT_W-1:0] load_count,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    byte_arr_t          bytes_reg;
    byte_arr_t          bytes_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;

    // A new burst may enter once the current one is empty or ends this cycle.
    assign can_load = (cnt_reg == '0) || ((cnt_reg == COUNT_W'(1)) && m_tready);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (cnt_reg == COUNT_W'(1));

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (load) begin
            bytes_next = load_bytes;
            cnt_next   = load_count;
        end else if (m_tvalid && m_tready) begin
            bytes_next = {8'h00, bytes_reg[MAX_BYTES-1:1]};
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

>>> sv/midi_track_event_encoder_unit.sv
// Top level of the MIDI track event encoder.
//
// The slave channel takes one track item per handshake: s_tuser carries the
// item kind and s_tdata the remaining fields. The master channel sends the
// encoded track one byte per handshake, with m_tlast on the final byte of
// each input item. Delay items, skipped key items and unused kinds cause no
// bytes. An accepted item is held in the input register until the result
// register can take it; the encoder then turns it, with the pending delay
// and running status, into up to seven bytes loaded into the result
// register, whose first byte then shows on m_tdata. The result register
// drains one byte a cycle while m_tready is high, and that byte rate of the
// output port sets the throughput. The input register refills while the
// result register still drains, and a new burst loads in the same cycle
// the last byte leaves.
// Reset clears the pending delay, the running status and both valid flags.
// When the receiver stalls, the current byte holds steady, the input
// register fills and s_tready then stays low until the last byte of the
// current burst leaves.
module midi_track_event_encoder_unit
    import mtee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [3:0]           s_tuser,   // mode
    // channel[3:0], first_data[12:4], second_data[20:13], wheel_value[34:21],
    // delay_ticks[50:35], zero fill[55:51]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // out_byte[7:0]
    output logic                 m_tlast
);

    item_t              item_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [DELAY_W-1:0] pending_reg;
    logic [7:0]         status_reg;
    enc_result_t        enc;
    logic               can_load;
    logic               load;

    // The input register hands its item over when the result side can take it.
    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            pending_reg  <= '0;
            status_reg   <= 8'h00;
        end else begin
            in_valid_reg <= in_valid_next;
            if (load) begin
                pending_reg <= enc.pending_next;
                status_reg  <= enc.status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            item_reg.mode        <= s_tuser;
            item_reg.channel     <= s_tdata[3:0];
            item_reg.first_data  <= s_tdata[12:4];
            item_reg.second_data <= s_tdata[20:13];
            item_reg.wheel_value <= s_tdata[34:21];
            item_reg.delay_ticks <= s_tdata[50:35];
        end
    end

    mtee_encode u_encode (
        .item        (item_reg),
        .pending     (pending_reg),
        .last_status (status_reg),
        .result      (enc)
    );

    mtee_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_bytes (enc.bytes),
        .load_count (enc.count),
        .can_load   (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> sv/mtee_checker.sv
// Port-level checks of the MIDI track event encoder and their binding.
module mtee_checker
    import mtee_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // No byte is offered while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // With the result register empty the block always takes an item.
    assert property (@(posedge clk) disable iff (!rst_n) !m_tvalid |-> s_tready)
        else $error("input stalled while output is idle");

    // A stalled byte keeps its value and its end mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output byte changed");

endmodule

bind midi_track_event_encoder_unit mtee_checker u_mtee_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> test/tb_midi_track_event_encoder_unit.sv
// Self-checking testbench for the MIDI track event encoder top level.
module tb_midi_track_event_encoder_unit;
    import mtee_pkg::*;

    // Delay ticks saturate at 28 bits of all ones.
    localparam logic [27:0] TICKS_LIMIT = 28'hFFF_FFFF;
    localparam int          MODE_CODES  = 16;
    localparam int          TICKS_FULL  = 65535;
    localparam int          PRINT_CAP   = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } track_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [3:0]           s_tuser;   // mode
    // channel[3:0], first_data[12:4], second_data[20:13], wheel_value[34:21],
    // delay_ticks[50:35], zero fill[55:51]
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // out_byte[7:0]
    logic                 m_tlast;

    // Bytes the track should carry, oldest first, plus the encoder state
    // that decides them: ticks not yet written and the running status.
    track_byte_t track_bytes_q[$];
    logic [27:0] pending_ticks;
    logic [7:0]  model_status;
    int          mismatch_count;
    logic        no_idle;

    midi_track_event_encoder_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Per-item idle count; at least half the draws are zero so back-to-back traffic
    // mixes with long gaps, and no_idle turns gaps off for whole stretches.
    function automatic int draw_idle();
        if (no_idle || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Works out the bytes one accepted item adds to the track and updates
    // the pending ticks and running status the same way the encoder must.
    task automatic predict_track_bytes(input item_t it);
        logic [7:0]  burst[$];
        logic [7:0]  status;
        logic [27:0] t;
        track_byte_t tb;
        status = '0;
        case (it.mode)
            MODE_DELAY:
            begin
                if ({12'd0, it.delay_ticks} >= TICKS_LIMIT - pending_ticks)
                begin
                    pending_ticks = TICKS_LIMIT;
                end
                else
                begin
                    pending_ticks = pending_ticks + it.delay_ticks;
                end
                return;
            end
            MODE_KEY_ON:    status = KIND_NOTE_ON;
            MODE_KEY_OFF:   status = KIND_NOTE_OFF;
            MODE_KEY_TOUCH: status = KIND_TOUCH;
            MODE_CONTROL:   status = KIND_CONTROL;
            MODE_PATCH:     status = KIND_PATCH;
            MODE_WHEEL:     status = KIND_WHEEL;
            MODE_META, MODE_PAYLOAD: ;
            default:        return;
        endcase

        // A key event with a negative note is dropped without a trace.
        if (it.mode >= MODE_KEY_ON && it.mode <= MODE_KEY_TOUCH && it.first_data[8])
        begin
            return;
        end

        // Every event but a raw payload byte first writes the delta time as
        // a variable-length quantity, most significant group first.
        if (it.mode != MODE_PAYLOAD)
        begin
            t = pending_ticks;
            for (int g = 3; g >= 1; g--)
            begin
                if ((t >> (7 * g)) != 0)
                begin
                    burst.insert(burst.size(), VLQ_MORE | (8'(t >> (7 * g)) & SEVEN_MASK));
                end
            end
            burst.insert(burst.size(), 8'(t) & SEVEN_MASK);
            pending_ticks = '0;
        end

        // Channel events send their status only when running status changes.
        if (it.mode >= MODE_KEY_ON && it.mode <= MODE_WHEEL)
        begin
            status = status | {4'd0, it.channel};
            if (status != model_status)
            begin
                model_status = status;
                burst.insert(burst.size(), status);
            end
        end

        case (it.mode)
            MODE_PATCH, MODE_PAYLOAD:
            begin
                burst.insert(burst.size(), it.first_data[7:0]);
            end
            MODE_WHEEL:
            begin
                burst.insert(burst.size(), {1'b0, it.wheel_value[6:0]});
                burst.insert(burst.size(), {1'b0, it.wheel_value[13:7]});
            end
            MODE_META:
            begin
                burst.insert(burst.size(), META_MARK);
                burst.insert(burst.size(), it.first_data[7:0]);
                burst.insert(burst.size(), it.second_data);
            end
            default:
            begin
                burst.insert(burst.size(), it.first_data[7:0]);
                burst.insert(burst.size(), it.second_data);
            end
        endcase

        foreach (burst[i])
        begin
            tb.data = burst[i];
            tb.last = (i == burst.size() - 1);
            track_bytes_q.insert(track_bytes_q.size(), tb);
        end
    endtask

    function automatic item_t make_item(input logic [3:0] mode, input logic [3:0] channel,
                                        input logic [8:0] first, input logic [7:0] second,
                                        input logic [13:0] wheel, input logic [15:0] ticks);
        item_t it;
        it.mode        = mode;
        it.channel     = channel;
        it.first_data  = first;
        it.second_data = second;
        it.wheel_value = wheel;
        it.delay_ticks = ticks;
        return it;
    endfunction

    // Random fields for the given mode. Channels favor a few values so that
    // running status is often reused; key notes stay non-negative here.
    function automatic item_t rand_item(input logic [3:0] mode);
        item_t it;
        it.mode        = mode;
        it.channel     = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 2));
        it.first_data  = {1'b0, 8'($urandom)};
        it.second_data = 8'($urandom);
        it.wheel_value = 14'($urandom);
        it.delay_ticks = $urandom_range(0, 1) ? 16'($urandom_range(0, 300))
                                              : 16'($urandom_range(0, TICKS_FULL));
        if ((mode < MODE_KEY_ON || mode > MODE_KEY_TOUCH) && $urandom_range(0, 5) == 0)
        begin
            it.first_data[8] = 1'b1;
        end
        return it;
    endfunction

    // Presents one item, holds it until the handshake, predicts its bytes.
    // Called at a falling edge and returns at a falling edge.
    task automatic send_item(input item_t it);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  <= it.mode;
        s_tdata  <= {5'd0, it.delay_ticks, it.wheel_value, it.second_data,
                     it.first_data, it.channel};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_track_bytes(it);
        @(negedge clk);
    endtask

    // Holds off the sender until every predicted byte has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (track_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Status is sent once, then dropped while kind and channel repeat.
    task automatic test_status_reuse();
        send_item(make_item(MODE_KEY_ON, 4'd0, 9'd0, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_KEY_ON, 4'd0, 9'd127, 8'd255, 14'd0, 16'd0));
        send_item(make_item(MODE_KEY_OFF, 4'd15, 9'd255, 8'd128, 14'd0, 16'd0));
        send_item(make_item(MODE_KEY_TOUCH, 4'd15, 9'd60, 8'd100, 14'd0, 16'd0));
        send_item(make_item(MODE_CONTROL, 4'd7, 9'd64, 8'd127, 14'd0, 16'd0));
    endtask

    // A meta header with its payload must not disturb running status.
    task automatic test_meta_keeps_status();
        send_item(make_item(MODE_META, 4'd3, 9'h02F, 8'd3, 14'd0, 16'd0));
        send_item(make_item(MODE_PAYLOAD, 4'd0, 9'h000, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_PAYLOAD, 4'd0, 9'h0FF, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_PAYLOAD, 4'd0, 9'h155, 8'd0, 14'd0, 16'd0));
        wait_for_drain();
        send_item(make_item(MODE_CONTROL, 4'd7, 9'd1, 8'd2, 14'd0, 16'd0));
    endtask

    task automatic test_wheel_and_patch();
        send_item(make_item(MODE_PATCH, 4'd1, 9'd0, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_WHEEL, 4'd1, 9'd0, 8'd0, 14'h3FFF, 16'd0));
        send_item(make_item(MODE_WHEEL, 4'd1, 9'd0, 8'd0, 14'h0000, 16'd0));
        send_item(make_item(MODE_WHEEL, 4'd1, 9'd0, 8'd0, 14'h2A55, 16'd0));
    endtask

    // Delta times around the one, two and three byte boundaries.
    task automatic test_delay_encoding();
        send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'h007F));
        send_item(make_item(MODE_PATCH, 4'd2, 9'd5, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'h0080));
        send_item(make_item(MODE_PATCH, 4'd2, 9'd6, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'h3FFF));
        send_item(make_item(MODE_PATCH, 4'd2, 9'd7, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'h4000));
        send_item(make_item(MODE_PATCH, 4'd2, 9'd8, 8'd0, 14'd0, 16'd0));
        send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'hFFFF));
        send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'h0000));
        send_item(make_item(MODE_META, 4'd2, 9'h051, 8'd0, 14'd0, 16'd0));
    endtask

    // Negative notes, unused modes and payload bytes leave the pending
    // delay alone; the following control event must flush all of it.
    task automatic test_skipped_items();
        send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'd100));
        send_item(make_item(MODE_KEY_ON, 4'd4, 9'h1FF, 8'd90, 14'd0, 16'd0));
        send_item(make_item(MODE_KEY_OFF, 4'd4, 9'h100, 8'd90, 14'd0, 16'd0));
        send_item(make_item(MODE_KEY_TOUCH, 4'd4, 9'h1C0, 8'd90, 14'd0, 16'd0));
        send_item(rand_item(4'(int'(MODE_PAYLOAD) + 1)));
        send_item(rand_item(4'(MODE_CODES - 1)));
        send_item(make_item(MODE_PAYLOAD, 4'd9, 9'h080, 8'd33, 14'h1234, 16'd500));
        send_item(make_item(MODE_CONTROL, 4'd4, 9'h1AA, 8'd0, 14'd0, 16'd0));
    endtask

    // Enough full delays for a four byte delta.
    task automatic test_long_delay();
        wait_for_drain();
        no_idle = 1'b1;
        repeat (33) send_item(make_item(MODE_DELAY, 4'd0, 9'd0, 8'd0, 14'd0, 16'hFFFF));
        send_item(make_item(MODE_KEY_ON, 4'd5, 9'd70, 8'd80, 14'd0, 16'd0));
        no_idle = 1'b0;
    endtask

    // Mostly well-formed sequences (delays then an event, meta headers with
    // their payload), with noise, drains and idle-free stretches mixed in.
    task automatic test_random_traffic();
        int   done;
        int   pick;
        int   n;
        item_t it;
        done = 0;
        while (done < 210)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                no_idle = ~no_idle;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                n = $urandom_range(0, 2);
                repeat (n) send_item(rand_item(MODE_DELAY));
                send_item(rand_item(4'($urandom_range(MODE_KEY_ON, MODE_WHEEL))));
                done += n + 1;
            end
            else if (pick < 70)
            begin
                n = $urandom_range(0, 4);
                it = rand_item(MODE_META);
                it.second_data = 8'(n);
                send_item(it);
                repeat (n) send_item(rand_item(MODE_PAYLOAD));
                done += n + 1;
            end
            else if (pick < 73)
            begin
                n = $urandom_range(33, 70);
                repeat (n)
                begin
                    it = rand_item(MODE_DELAY);
                    it.delay_ticks = 16'($urandom_range(32768, TICKS_FULL));
                    send_item(it);
                end
                send_item(rand_item(4'($urandom_range(MODE_KEY_ON, MODE_META))));
                done += n + 1;
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        it = rand_item(4'($urandom_range(MODE_KEY_ON, MODE_KEY_TOUCH)));
                        it.first_data[8] = 1'b1;
                        send_item(it);
                    end
                    1:
                    begin
                        send_item(rand_item(4'($urandom_range(int'(MODE_PAYLOAD) + 1,
                                                              MODE_CODES - 1))));
                    end
                    default:
                    begin
                        send_item(rand_item(MODE_PAYLOAD));
                    end
                endcase
                done++;
            end
            else if (pick < 88)
            begin
                wait_for_drain();
            end
            else
            begin
                send_item(rand_item(4'($urandom_range(MODE_KEY_ON, MODE_PAYLOAD))));
                done++;
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver: stalls a random number of cycles before each byte.
    initial
    begin : receiver
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_idle();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Compares every accepted byte with the oldest predicted one.
    always @(posedge clk)
    begin : byte_check
        track_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (track_bytes_q.size() == 0)
            begin
                report_mismatch($sformatf("byte %02h with none predicted", m_tdata));
            end
            else
            begin
                want = track_bytes_q.pop_front();
                if (m_tdata !== want.data)
                begin
                    report_mismatch($sformatf("byte %02h, predicted %02h",
                                              m_tdata, want.data));
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch($sformatf("tlast %b, predicted %b on byte %02h",
                                              m_tlast, want.last, want.data));
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = '0;
        s_tdata        = '0;
        pending_ticks  = '0;
        model_status   = '0;
        mismatch_count = 0;
        no_idle        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_status_reuse();
        test_meta_keeps_status();
        test_wheel_and_patch();
        test_delay_encoding();
        test_skipped_items();
        test_long_delay();
        test_random_traffic();

        wait_for_drain();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
